[rtl/mss_pkg.sv]
// shared types and constants for the marker stream splitter
package mss_pkg;

  // default number of marker cells and held-byte slots
  localparam int TAG_MAX_DEF = 16;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int TAG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_EXPECT_OPEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TAG_LO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TAG_HI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TAG_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TAG_HI = 3'd6;

  // request action codes
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // stream mode codes
  localparam logic MODE_CONTENT   = 1'b0;
  localparam logic MODE_REASONING = 1'b1;

  // settings seen by the datapath, lengths already clamped
  typedef struct packed {
    logic             expect_open;
    logic [LEN_W-1:0] open_len;
    logic [LEN_W-1:0] close_len;
  } cfg_view_t;

  // per-cycle control of one byte cell of the line
  typedef struct packed {
    logic shift;
    logic load;
  } line_ctl_t;

  // per-cycle control of the match cells
  typedef struct packed {
    logic clear;
    logic scan;
  } match_ctl_t;

endpackage

[rtl/mss_if.sv]
// channel interfaces: input requests, released bytes, configuration writes
interface mss_in_if;
  import mss_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface mss_out_if;
  import mss_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_reasoning;
  logic              last;
  modport source (output valid, out_byte, is_reasoning, last, input ready);
  modport sink   (input valid, out_byte, is_reasoning, last, output ready);
endinterface

interface mss_cfg_if;
  import mss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/mss_line_cell.sv]
// one byte cell of the holding line, shifts toward the front on release
module mss_line_cell (
  input  logic                       clk,
  input  mss_pkg::line_ctl_t         ctl,
  input  logic [mss_pkg::BYTE_W-1:0] right_byte,
  input  logic [mss_pkg::BYTE_W-1:0] new_byte,
  output logic [mss_pkg::BYTE_W-1:0] cell_byte
);
  import mss_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  // take the neighbor's byte on release, or the incoming byte on append
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      byte_nxt = right_byte;
    end else if (ctl.load) begin
      byte_nxt = new_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign cell_byte = byte_r;

endmodule

[rtl/mss_match_cell.sv]
// one marker position: tracks a partial match of length CELL_IDX + 1
module mss_match_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mss_pkg::match_ctl_t        ctl,
  input  logic                       prev_act,
  input  logic [mss_pkg::BYTE_W-1:0] scan_byte,
  input  logic [mss_pkg::BYTE_W-1:0] tag_byte,
  input  logic [mss_pkg::LEN_W-1:0]  tag_len,
  output logic                       act,
  output logic                       hit
);
  import mss_pkg::*;

  logic act_r;
  logic act_nxt;
  logic in_rng;

  // cell only takes part when it lies inside the current marker
  assign in_rng = int'(tag_len) > CELL_IDX;

  // neighbor matched one byte shorter and this byte continues the marker
  assign hit = prev_act && in_rng && (scan_byte == tag_byte);

  always_comb begin
    act_nxt = act_r;
    if (ctl.clear) begin
      act_nxt = 1'b0;
    end else if (ctl.scan) begin
      act_nxt = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  assign act = act_r;

endmodule

[rtl/mss_cfg.sv]
// configuration registers, clamped marker lengths and marker byte lanes
module mss_cfg #(
  parameter int TAG_MAX = mss_pkg::TAG_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mss_cfg_if.sink                    cfg_chan,
  output mss_pkg::cfg_view_t         view,
  output logic [mss_pkg::BYTE_W-1:0] open_byte  [TAG_MAX],
  output logic [mss_pkg::BYTE_W-1:0] close_byte [TAG_MAX]
);
  import mss_pkg::*;

  localparam int LEN_CAP   = (TAG_MAX < 31) ? TAG_MAX : 31;
  localparam int TAG_BYTES = TAG_W / BYTE_W;

  logic             expect_open_r;
  logic [LEN_W-1:0] open_len_r;
  logic [LEN_W-1:0] close_len_r;
  logic [TAG_W-1:0] open_lo_r;
  logic [TAG_W-1:0] open_hi_r;
  logic [TAG_W-1:0] close_lo_r;
  logic [TAG_W-1:0] close_hi_r;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    return (int'(len) > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
  endfunction

  assign cfg_chan.ready = 1'b1;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_open_r <= 1'b0;
      open_len_r    <= '0;
      close_len_r   <= '0;
      open_lo_r     <= '0;
      open_hi_r     <= '0;
      close_lo_r    <= '0;
      close_hi_r    <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_EXPECT_OPEN:  expect_open_r <= cfg_chan.data[0];
        REG_OPEN_LEN:     open_len_r    <= cfg_chan.data[LEN_W-1:0];
        REG_CLOSE_LEN:    close_len_r   <= cfg_chan.data[LEN_W-1:0];
        REG_OPEN_TAG_LO:  open_lo_r     <= cfg_chan.data;
        REG_OPEN_TAG_HI:  open_hi_r     <= cfg_chan.data;
        REG_CLOSE_TAG_LO: close_lo_r    <= cfg_chan.data;
        REG_CLOSE_TAG_HI: close_hi_r    <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign view.expect_open = expect_open_r;
  assign view.open_len    = eff_len(open_len_r);
  assign view.close_len   = eff_len(close_len_r);

  // marker byte per cell, bytes past the two registers read as zero
  for (genvar k = 0; k < TAG_MAX; k++) begin : g_lane
    if (k < TAG_BYTES) begin : g_lo
      assign open_byte[k]  = open_lo_r[k*BYTE_W +: BYTE_W];
      assign close_byte[k] = close_lo_r[k*BYTE_W +: BYTE_W];
    end else if (k < 2 * TAG_BYTES) begin : g_hi
      assign open_byte[k]  = open_hi_r[(k-TAG_BYTES)*BYTE_W +: BYTE_W];
      assign close_byte[k] = close_hi_r[(k-TAG_BYTES)*BYTE_W +: BYTE_W];
    end else begin : g_zero
      assign open_byte[k]  = '0;
      assign close_byte[k] = '0;
    end
  end

endmodule

[rtl/marker_stream_splitter.sv]
// top level: byte line, marker match cells and release sequencer
// A data request with L buffered bytes (held bytes plus the new one, L <= TAG_MAX)
// is worked off in the line: the line scans one byte and releases one byte
// per cycle while the output can take it, and a dropped marker leaves the line
// one byte per cycle. A flush releases every held byte. One request at a time.
// Synchronous reset clears counters, handshakes and settings and puts the mode
// in reasoning; held bytes are tracked by a count, so there is no clearing pass.
module marker_stream_splitter #(
  parameter int TAG_MAX = mss_pkg::TAG_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mss_in_if.sink     in_chan,
  mss_out_if.source  out_chan,
  mss_cfg_if.sink    cfg_chan
);
  import mss_pkg::*;

  localparam int CNT_W = $clog2(TAG_MAX + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  q_r, q_nxt;
  logic              reas_mode_r, reas_mode_nxt;
  logic              mark_r, mark_nxt;
  logic              flush_r, flush_nxt;
  logic              stg_v_r, stg_v_nxt;
  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] stg_byte_r;
  logic              stg_reas_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_reas_r;
  logic              out_last_r;

  cfg_view_t         view;
  logic [BYTE_W-1:0] open_byte  [TAG_MAX];
  logic [BYTE_W-1:0] close_byte [TAG_MAX];
  logic [BYTE_W-1:0] tag_sel    [TAG_MAX];
  logic [BYTE_W-1:0] line_byte  [TAG_MAX];
  line_ctl_t         lctl       [TAG_MAX];
  logic [TAG_MAX-1:0] act;
  logic [TAG_MAX-1:0] hit;
  match_ctl_t        mctl;

  logic [LEN_W-1:0]  tl;
  logic [CMP_W-1:0]  tl_c;
  logic [CMP_W-1:0]  q_c;
  logic [BYTE_W-1:0] scan_byte;
  logic              front_act;
  logic              pop_need;
  logic              full;
  logic              skip_close;
  logic              in_acc;
  logic              load_en;
  logic              can_emit;
  logic              emit_ok;
  logic              pop;
  logic              do_emit;
  logic              scan;
  logic              fin;
  logic              fin_move;
  logic              match_clear;

  // settings
  mss_cfg #(
    .TAG_MAX (TAG_MAX)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_chan   (cfg_chan),
    .view       (view),
    .open_byte  (open_byte),
    .close_byte (close_byte)
  );

  // marker being sought in the current mode
  assign tl         = reas_mode_r ? view.close_len : view.open_len;
  assign tl_c       = CMP_W'(tl);
  assign q_c        = CMP_W'(q_r);
  assign skip_close = (reas_mode_r == MODE_REASONING) && (view.close_len == '0);

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign load_en = in_acc && (in_chan.action == ACT_DATA);

  assign mctl.clear = match_clear;
  assign mctl.scan  = scan;

  // row of cells: one line byte and one match position each
  for (genvar k = 0; k < TAG_MAX; k++) begin : g_cell
    logic              prev_act;
    logic [BYTE_W-1:0] right_byte;

    assign tag_sel[k] = reas_mode_r ? close_byte[k] : open_byte[k];

    if (k == 0) begin : g_first
      assign prev_act = 1'b1;
    end else begin : g_chain
      assign prev_act = act[k-1];
    end

    if (k == TAG_MAX - 1) begin : g_tail
      assign right_byte = line_byte[k];
    end else begin : g_body
      assign right_byte = line_byte[k+1];
    end

    assign lctl[k].shift = pop;
    assign lctl[k].load  = load_en && (len_r == CNT_W'(k));

    mss_line_cell u_line (
      .clk        (clk),
      .ctl        (lctl[k]),
      .right_byte (right_byte),
      .new_byte   (in_chan.data_byte),
      .cell_byte  (line_byte[k])
    );

    mss_match_cell #(
      .CELL_IDX (k)
    ) u_match (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (mctl),
      .prev_act  (prev_act),
      .scan_byte (scan_byte),
      .tag_byte  (tag_sel[k]),
      .tag_len   (tl),
      .act       (act[k]),
      .hit       (hit[k])
    );
  end

  // next unscanned byte, liveness of the oldest pending byte, full marker hit
  always_comb begin
    scan_byte = '0;
    front_act = 1'b0;
    full      = 1'b0;
    for (int j = 0; j < TAG_MAX; j++) begin
      if (q_r == CNT_W'(j)) begin
        scan_byte = line_byte[j];
      end
      if (q_r == CNT_W'(j + 1)) begin
        front_act = act[j];
      end
      if (tl_c == CMP_W'(j + 1)) begin
        full = hit[j];
      end
    end
  end

  // a pending byte at the front that starts no live partial match goes out
  assign pop_need = (q_r != '0) && !front_act;

  assign can_emit = !out_v_r || out_chan.ready;
  assign emit_ok  = !stg_v_r || can_emit;

  // release sequencer
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    q_nxt         = q_r;
    reas_mode_nxt = reas_mode_r;
    mark_nxt      = mark_r;
    flush_nxt     = flush_r;
    stg_v_nxt     = stg_v_r;
    out_v_nxt     = out_v_r && !out_chan.ready;
    pop           = 1'b0;
    do_emit       = 1'b0;
    scan          = 1'b0;
    fin           = 1'b0;
    fin_move      = 1'b0;
    match_clear   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt   = ST_RUN;
          flush_nxt   = (in_chan.action == ACT_FLUSH);
          q_nxt       = '0;
          mark_nxt    = 1'b0;
          match_clear = 1'b1;
          if (in_chan.action == ACT_DATA) begin
            len_nxt = len_r + CNT_W'(1);
          end
        end
      end
      ST_RUN: begin
        if (flush_r) begin
          // flush: release every held byte
          do_emit = (len_r != '0) && emit_ok;
          pop     = do_emit;
          fin     = (len_r == '0);
        end else if (mark_r) begin
          // marker found: release bytes before it, then drop the marker
          if (q_c > tl_c) begin
            do_emit = emit_ok;
            pop     = do_emit;
          end else begin
            pop = 1'b1;
            if (q_r == CNT_W'(1)) begin
              reas_mode_nxt = !reas_mode_r;
              mark_nxt      = 1'b0;
            end
          end
        end else begin
          // scan one byte and release one byte per cycle while the output can take it
          do_emit = pop_need && emit_ok;
          pop     = do_emit;
          scan    = (q_r < len_r) && !skip_close;
          if ((q_r < len_r) && skip_close) begin
            reas_mode_nxt = MODE_CONTENT;
          end
          fin = (q_r == len_r) && !pop_need;
          if (scan && full) begin
            mark_nxt    = 1'b1;
            match_clear = 1'b1;
          end
        end
        len_nxt = len_r - CNT_W'(pop);
        q_nxt   = q_r - CNT_W'(pop && !flush_r) + CNT_W'(scan);
        if (do_emit) begin
          stg_v_nxt = 1'b1;
        end
        // end of request: last byte goes out tagged, flush restores the start mode
        if (fin && (!stg_v_r || can_emit)) begin
          fin_move  = stg_v_r;
          stg_v_nxt = 1'b0;
          state_nxt = ST_IDLE;
          if (flush_r) begin
            reas_mode_nxt = !view.expect_open;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if ((do_emit && stg_v_r) || fin_move) begin
      out_v_nxt = 1'b1;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      q_r         <= '0;
      reas_mode_r <= MODE_REASONING;
      mark_r      <= 1'b0;
      flush_r     <= 1'b0;
      stg_v_r     <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      q_r         <= q_nxt;
      reas_mode_r <= reas_mode_nxt;
      mark_r      <= mark_nxt;
      flush_r     <= flush_nxt;
      stg_v_r     <= stg_v_nxt;
      out_v_r     <= out_v_nxt;
    end
    if (do_emit) begin
      stg_byte_r <= line_byte[0];
      stg_reas_r <= reas_mode_r;
    end
    if ((do_emit && stg_v_r) || fin_move) begin
      out_byte_r <= stg_byte_r;
      out_reas_r <= stg_reas_r;
      out_last_r <= fin_move;
    end
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_v_r;
  assign out_chan.out_byte     = out_byte_r;
  assign out_chan.is_reasoning = out_reas_r;
  assign out_chan.last         = out_last_r;

  // scanned bytes never run past the line contents
  a_q_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    q_r <= len_r)
    else $error("scan position past line end");

  // line never holds more than one marker's worth of bytes
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CNT_W'(TAG_MAX))
    else $error("line overflow");

  // a new request is only taken once the staged byte has gone out
  a_idle_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !stg_v_r)
    else $error("staged byte left behind at end of request");

  // a data request appends exactly one byte to the line
  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    load_en |=> (len_r == $past(len_r) + CNT_W'(1)))
    else $error("data request did not append its byte");

  // an empty flush with nothing staged finishes at once
  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && flush_r && (len_r == '0) && !stg_v_r) |=>
      (state_r == ST_IDLE))
    else $error("empty flush did not finish");

endmodule

[test/marker_stream_splitter_tb.sv]
// testbench for the marker stream splitter: scoreboard class and top module
`timescale 1ns / 1ps

import mss_pkg::*;

// one released byte as the result channel carries it
typedef struct {
  logic [BYTE_W-1:0] value;
  logic              reasoning;
  logic              last;
} release_t;

// predicts the released bytes of each request and checks them in order
class release_scoreboard;
  localparam int SCAN_CAP = 2 * (TAG_MAX_DEF + 2) + 4;

  release_t          expected_releases[$];
  release_t          batch[$];
  logic              expect_open;
  logic [LEN_W-1:0]  open_len;
  logic [LEN_W-1:0]  close_len;
  logic [TAG_W-1:0]  open_lo, open_hi, close_lo, close_hi;
  logic              reasoning;
  logic [BYTE_W-1:0] held[TAG_MAX_DEF+1];
  int                held_count;
  int                errors, requests, flushes, checked, reasoning_bytes;

  function new();
    expect_open = 1'b0;
    open_len = '0;
    close_len = '0;
    open_lo = '0;
    open_hi = '0;
    close_lo = '0;
    close_hi = '0;
    reasoning = MODE_REASONING;
    foreach (held[k]) held[k] = '0;
    held_count = 0;
    errors = 0;
    requests = 0;
    flushes = 0;
    checked = 0;
    reasoning_bytes = 0;
  endfunction

  // register write, unlisted indexes are dropped
  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_EXPECT_OPEN:  expect_open = value[0];
      REG_OPEN_LEN:     open_len = value[LEN_W-1:0];
      REG_CLOSE_LEN:    close_len = value[LEN_W-1:0];
      REG_OPEN_TAG_LO:  open_lo = value;
      REG_OPEN_TAG_HI:  open_hi = value;
      REG_CLOSE_TAG_LO: close_lo = value;
      REG_CLOSE_TAG_HI: close_hi = value;
      default: ;
    endcase
  endfunction

  function int clamp_len(logic [LEN_W-1:0] len);
    return (len > TAG_MAX_DEF) ? TAG_MAX_DEF : int'(len);
  endfunction

  function logic [BYTE_W-1:0] marker_byte(logic is_close, int i);
    logic [TAG_W-1:0] lo, hi;
    lo = is_close ? close_lo : open_lo;
    hi = is_close ? close_hi : open_hi;
    if (i < 8) return lo[i*8 +: 8];
    if (i < 16) return hi[(i-8)*8 +: 8];
    return '0;
  endfunction

  // release bytes from..upto-1 in the current mode, capped per request
  function void release_span(logic [BYTE_W-1:0] line[TAG_MAX_DEF+1], int from, int upto);
    release_t r;
    for (int k = from; k < upto && batch.size() < TAG_MAX_DEF + 1; k++) begin
      r.value = line[k];
      r.reasoning = reasoning;
      r.last = 1'b0;
      batch.push_back(r);
    end
  endfunction

  // accepted request: run the matcher and queue what it releases
  function void note_request(logic action, logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] line[TAG_MAX_DEF+1];
    int len, start, held_n, tl, olen, p, i, hold, lim;
    logic is_close, found, hit;
    batch.delete();
    requests++;
    held_n = held_count;
    for (int k = 0; k <= TAG_MAX_DEF; k++) line[k] = (k < held_n) ? held[k] : '0;
    if (action == ACT_FLUSH) begin
      flushes++;
      release_span(line, 0, held_n);
      held_count = 0;
      reasoning = expect_open ? MODE_CONTENT : MODE_REASONING;
    end else begin
      line[held_n] = data;
      len = held_n + 1;
      held_count = 0;
      start = 0;
      for (int iter = 0; iter < SCAN_CAP && start < len; iter++) begin
        olen = clamp_len(open_len);
        is_close = (reasoning == MODE_REASONING);
        tl = is_close ? clamp_len(close_len) : olen;
        found = 1'b0;
        p = start;
        // no open marker: everything in content goes straight out
        if (!is_close && olen == 0) begin
          release_span(line, start, len);
          start = len;
          break;
        end
        if (tl == 0) begin
          found = 1'b1;
        end else begin
          for (p = start; p + tl <= len; p++) begin
            hit = 1'b1;
            for (i = 0; i < tl; i++)
              if (line[p+i] != marker_byte(is_close, i)) hit = 1'b0;
            if (hit) begin
              found = 1'b1;
              break;
            end
          end
        end
        // marker found: release what precedes it, drop it, flip the mode
        if (found) begin
          release_span(line, start, p);
          reasoning = ~reasoning;
          start = p + tl;
          continue;
        end
        // longest suffix that is still a marker prefix stays held
        hold = 0;
        lim = (len - start < tl) ? len - start : tl;
        for (p = 1; p <= lim; p++) begin
          hit = 1'b1;
          for (i = 0; i < p; i++)
            if (line[len-p+i] != marker_byte(is_close, i)) hit = 1'b0;
          if (hit) hold = p;
        end
        release_span(line, start, len - hold);
        for (i = 0; i < hold; i++) held[i] = line[len-hold+i];
        held_count = hold;
        break;
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) expected_releases.push_back(batch[k]);
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // accepted result against the oldest expectation
  task check_release(logic [BYTE_W-1:0] value, logic reas, logic last);
    release_t want;
    checked++;
    if (reas) reasoning_bytes++;
    if (expected_releases.size() == 0) begin
      report($sformatf("byte %0d: %02h released with nothing expected", checked, value));
      return;
    end
    want = expected_releases.pop_front();
    if (value !== want.value)
      report($sformatf("byte %0d: out_byte %02h, wanted %02h", checked, value, want.value));
    if (reas !== want.reasoning)
      report($sformatf("byte %0d: is_reasoning %b, wanted %b", checked, reas, want.reasoning));
    if (last !== want.last)
      report($sformatf("byte %0d: last %b, wanted %b", checked, last, want.last));
  endtask
endclass

module marker_stream_splitter_tb;
  localparam int DRAIN_CYCLES = 2 * TAG_MAX_DEF + 8;
  localparam int STALL_CYCLES = 300;
  localparam int TIMEOUT_NS = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNLISTED = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  mss_in_if  in_bus();
  mss_out_if out_bus();
  mss_cfg_if cfg_bus();

  release_scoreboard sb;
  int                send_idle_pct, recv_idle_pct;
  bit                stall_req, stall_done;
  int                setting_count;
  logic [BYTE_W-1:0] alpha[4];

  marker_stream_splitter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always #1 clk = ~clk;

  // offer one request after a random gap, wait for the handshake
  task send_request(logic action, logic [BYTE_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= action;
    in_bus.data_byte <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_request(action, value);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // all results in, then let the block finish any silent request
  task drain();
    in_bus.valid <= 1'b0;
    while (sb.expected_releases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task configure(logic eo, logic [LEN_W-1:0] olen, logic [LEN_W-1:0] clen,
                 logic [TAG_W-1:0] olo, logic [TAG_W-1:0] ohi,
                 logic [TAG_W-1:0] clo, logic [TAG_W-1:0] chi);
    drain();
    write_reg(REG_EXPECT_OPEN, {63'd0, eo});
    write_reg(REG_OPEN_LEN, {59'd0, olen});
    write_reg(REG_CLOSE_LEN, {59'd0, clen});
    write_reg(REG_OPEN_TAG_LO, olo);
    write_reg(REG_OPEN_TAG_HI, ohi);
    write_reg(REG_CLOSE_TAG_LO, clo);
    write_reg(REG_CLOSE_TAG_HI, chi);
    write_reg(REG_UNLISTED, {$urandom, $urandom});
    cfg_bus.valid <= 1'b0;
    setting_count++;
  endtask

  function logic [TAG_W-1:0] alpha_word();
    logic [TAG_W-1:0] w;
    for (int k = 0; k < 8; k++) w[k*8 +: 8] = alpha[$urandom_range(0, 3)];
    return w;
  endfunction

  function logic [TAG_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // whole and broken markers of the mode in force, single marker or alphabet bytes, noise and flushes
  task random_traffic(int count);
    int sent, r, tl, cut, k;
    logic is_close;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      is_close = (sb.reasoning == MODE_REASONING);
      tl = is_close ? sb.clamp_len(sb.close_len) : sb.clamp_len(sb.open_len);
      if (r < 30 && tl > 0) begin
        for (k = 0; k < tl; k++) send_request(ACT_DATA, sb.marker_byte(is_close, k));
        sent += tl;
      end else if (r < 45 && tl > 1) begin
        cut = $urandom_range(1, tl - 1);
        for (k = 0; k < cut; k++) send_request(ACT_DATA, sb.marker_byte(is_close, k));
        send_request(ACT_DATA, alpha[$urandom_range(0, 3)]);
        sent += cut + 1;
      end else if (r < 80) begin
        if ($urandom_range(0, 1))
          send_request(ACT_DATA, alpha[$urandom_range(0, 3)]);
        else
          send_request(ACT_DATA, sb.marker_byte(is_close, $urandom_range(0, 15)));
        sent++;
      end else if (r < 95) begin
        send_request(ACT_DATA, $urandom_range(0, 255));
        sent++;
      end else begin
        send_request(ACT_FLUSH, $urandom_range(0, 255));
        sent++;
      end
    end
  endtask

  // result side: random idling, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req && !stall_done) begin
        out_bus.ready <= 1'b0;
        hold_left++;
        if (hold_left >= STALL_CYCLES) stall_done = 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_release(out_bus.out_byte, out_bus.is_reasoning, out_bus.last);
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // main sequence
  initial begin
    sb = new();
    send_idle_pct = 16;
    recv_idle_pct = 60;
    stall_req = 1'b0;
    stall_done = 1'b0;
    setting_count = 0;
    alpha[0] = 8'h3C;
    alpha[1] = 8'h74;
    alpha[2] = 8'h2F;
    alpha[3] = 8'h3E;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.action <= ACT_DATA;
    in_bus.data_byte <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: open "<t>", close "</t>"
    configure(1'b1, 5'd3, 5'd4, 64'h3E743C, rand_word(), 64'h3E742F3C, rand_word());
    // flush with nothing held only restores content mode
    send_request(ACT_FLUSH, 8'hA5);
    send_request(ACT_DATA, 8'h00);
    send_request(ACT_DATA, 8'hFF);
    // open marker dropped, then a reasoning byte
    send_request(ACT_DATA, 8'h3C);
    send_request(ACT_DATA, 8'h74);
    send_request(ACT_DATA, 8'h3E);
    send_request(ACT_DATA, 8'h61);
    // broken close marker releases the held bytes
    send_request(ACT_DATA, 8'h3C);
    send_request(ACT_DATA, 8'h2F);
    send_request(ACT_DATA, 8'h78);
    // whole close marker back to content
    send_request(ACT_DATA, 8'h3C);
    send_request(ACT_DATA, 8'h2F);
    send_request(ACT_DATA, 8'h74);
    send_request(ACT_DATA, 8'h3E);
    // flush releases a held prefix
    send_request(ACT_DATA, 8'h3C);
    send_request(ACT_DATA, 8'h74);
    send_request(ACT_FLUSH, 8'h00);
    // overlapping start: first byte goes out, marker still found
    send_request(ACT_DATA, 8'h3C);
    send_request(ACT_DATA, 8'h3C);
    send_request(ACT_DATA, 8'h74);
    send_request(ACT_DATA, 8'h3E);
    random_traffic(40);

    // empty markers both ways
    configure(1'b0, 5'd0, 5'd0, rand_word(), rand_word(), rand_word(), rand_word());
    send_request(ACT_FLUSH, 8'h00);
    random_traffic(40);

    // no open marker, longest close marker
    alpha[0] = 8'h41;
    alpha[1] = 8'h42;
    alpha[2] = 8'h43;
    alpha[3] = $urandom_range(0, 255);
    configure(1'b0, 5'd0, 5'd16, rand_word(), rand_word(), alpha_word(), alpha_word());
    send_request(ACT_FLUSH, 8'hFF);
    random_traffic(45);

    // longest markers, all ones
    send_idle_pct = 60;
    recv_idle_pct = 16;
    alpha[0] = 8'hFF;
    alpha[1] = 8'hFF;
    alpha[2] = 8'h00;
    alpha[3] = $urandom_range(0, 255);
    configure(1'b1, 5'd16, 5'd16, '1, '1, '1, '1);
    send_request(ACT_FLUSH, 8'h00);
    random_traffic(45);

    // lengths past the marker size, with the long receiver hold-off
    alpha[0] = 8'h5B;
    alpha[1] = 8'h5D;
    alpha[2] = 8'h2F;
    alpha[3] = $urandom_range(0, 255);
    configure(1'b1, 5'd31, 5'd17, alpha_word(), alpha_word(), alpha_word(), alpha_word());
    send_request(ACT_FLUSH, 8'h00);
    stall_req = 1'b1;
    random_traffic(45);

    // one-byte markers
    configure(1'b1, 5'd1, 5'd1, alpha_word(), alpha_word(), alpha_word(), alpha_word());
    random_traffic(45);

    // arbitrary marker bytes, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 4; k++) alpha[k] = $urandom_range(0, 255);
    configure(1'b0, 5'd2, 5'd5, rand_word(), rand_word(), rand_word(), rand_word());
    random_traffic(45);

    // all-zero markers
    alpha[0] = 8'h00;
    alpha[1] = 8'h01;
    alpha[2] = 8'h80;
    alpha[3] = 8'hFF;
    configure(1'b1, 5'd4, 5'd6, '0, '0, '0, '0);
    send_request(ACT_FLUSH, 8'h00);
    random_traffic(45);

    drain();
    $display("covered %0d requests (%0d flushes) over %0d register settings",
             sb.requests, sb.flushes, setting_count);
    $display("checked %0d released bytes, %0d of them reasoning, after one %0d-cycle hold-off",
             sb.checked, sb.reasoning_bytes, STALL_CYCLES);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
